// File: rtl/fsiv_pkg.sv
// ----------------------------------------------------------------------------
// Flash slot image validator package
// Shared constants, register indexes and transaction types.
// ----------------------------------------------------------------------------
package fsiv_pkg;

	localparam int HEADER_BYTES = 20;
	localparam int SLOT_COUNT   = 2;
	localparam int SLOT_W       = $clog2(SLOT_COUNT);
	localparam int POS_W        = 17;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
	localparam logic [POS_W-1:0] CRC_COVERED = POS_W'(16);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXPECTED_MAGIC  = 2'd0,
		REG_EXPECTED_LAYOUT = 2'd1,
		REG_MAX_PAYLOAD     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic       slot;
		logic [7:0] data_byte;
		logic       first_byte;
		logic       read_failed;
	} in_item_t;

	typedef struct packed {
		logic        scanned_slot;
		logic        image_valid;
		logic [31:0] sequence_res;
		logic [15:0] image_version;
		logic [15:0] payload_length;
		logic        newest_present;
		logic        newest_slot;
	} out_item_t;

	typedef struct packed {
		logic        slot;
		logic        ok;
		logic [31:0] sequence_num;
		logic [15:0] version;
		logic [15:0] length;
	} verdict_t;

endpackage

// File: rtl/fsiv_in_if.sv
// ----------------------------------------------------------------------------
// Image byte channel
// Valid/ready channel carrying one image byte and its marks per transaction.
// ----------------------------------------------------------------------------
interface fsiv_in_if import fsiv_pkg::*; ();

	logic     valid;
	logic     ready;
	in_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);

endinterface

// File: rtl/fsiv_out_if.sv
// ----------------------------------------------------------------------------
// Verdict channel
// Valid/ready channel carrying one slot verdict per transaction.
// ----------------------------------------------------------------------------
interface fsiv_out_if import fsiv_pkg::*; ();

	logic      valid;
	logic      ready;
	out_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);

endinterface

// File: rtl/fsiv_front.sv
// ----------------------------------------------------------------------------
// Image parser
// Accepts image bytes, captures the header, runs the CRC and emits verdicts.
// ----------------------------------------------------------------------------
module fsiv_front import fsiv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  push,
	output verdict_t              push_data,
	input  logic                  queue_full
);

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

	logic [31:0] exp_magic_q;
	logic [15:0] exp_layout_q;
	logic [15:0] max_payload_q;

	logic             scan_q;
	logic             slot_q;
	logic [POS_W-1:0] pos_q;
	logic [31:0]      crc_q;
	logic [31:0]      magic_q;
	logic [15:0]      layout_q;
	logic [15:0]      version_q;
	logic [31:0]      sequence_q;
	logic [15:0]      length_q;
	logic [31:0]      stored_q;

	logic             acc;
	logic             active;
	logic             cur_slot;
	logic [POS_W-1:0] pos;
	logic [31:0]      crc_eff;
	logic [31:0]      crc_pay;
	logic [31:0]      stored_nx;
	logic [POS_W-1:0] end_pos;
	logic             at_hdr_end;
	logic             in_payload;
	logic             hdr_bad;
	logic             fin;
	logic             ok;

	assign in_ready = !queue_full;
	assign acc      = in_valid && in_ready;
	assign active   = in_item.first_byte || scan_q;
	assign cur_slot = in_item.first_byte ? in_item.slot : slot_q;
	assign pos      = in_item.first_byte ? '0 : pos_q;
	assign crc_eff  = in_item.first_byte ? CRC_INIT : crc_q;
	assign crc_pay  = crc_byte(crc_q, in_item.data_byte);
	assign end_pos  = POS_W'(HEADER_BYTES - 1) + {{(POS_W-16){1'b0}}, length_q};

	assign at_hdr_end = (pos == POS_W'(HEADER_BYTES - 1));
	assign in_payload = (pos >= POS_W'(HEADER_BYTES));
	assign hdr_bad    = (magic_q != exp_magic_q) || (layout_q != exp_layout_q) ||
		(length_q > max_payload_q);

	always_comb begin
		stored_nx = stored_q;
		if (pos >= POS_W'(16) && pos < POS_W'(20)) begin
			stored_nx[pos[1:0]*8 +: 8] = in_item.data_byte;
		end
	end

	always_comb begin
		fin = 1'b0;
		ok  = 1'b0;
		if (in_item.read_failed) begin
			fin = 1'b1;
		end else if (at_hdr_end) begin
			if (hdr_bad) begin
				fin = 1'b1;
			end else if (length_q == 16'd0) begin
				fin = 1'b1;
				ok  = (~crc_q == stored_nx);
			end
		end else if (in_payload && pos == end_pos) begin
			fin = 1'b1;
			ok  = (~crc_pay == stored_q);
		end
	end

	assign push                   = acc && active && fin;
	assign push_data.slot         = cur_slot;
	assign push_data.ok           = ok;
	assign push_data.sequence_num = sequence_q;
	assign push_data.version      = version_q;
	assign push_data.length       = length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_magic_q   <= '0;
			exp_layout_q  <= 16'd1;
			max_payload_q <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPECTED_MAGIC:  exp_magic_q   <= cfg_data;
				REG_EXPECTED_LAYOUT: exp_layout_q  <= cfg_data[15:0];
				REG_MAX_PAYLOAD:     max_payload_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= 1'b0;
			pos_q  <= '0;
			crc_q  <= CRC_INIT;
		end else if (acc && active) begin
			scan_q <= !fin;
			if (!in_item.read_failed) begin
				if (pos < CRC_COVERED) begin
					crc_q <= crc_byte(crc_eff, in_item.data_byte);
				end else if (in_payload) begin
					crc_q <= crc_pay;
				end
				if (!fin) begin
					pos_q <= pos + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && active) begin
			if (in_item.first_byte) begin
				slot_q     <= in_item.slot;
				layout_q   <= '0;
				version_q  <= '0;
				sequence_q <= '0;
				length_q   <= '0;
				stored_q   <= '0;
			end
			if (!in_item.read_failed) begin
				if (pos < POS_W'(4)) begin
					magic_q[pos[1:0]*8 +: 8] <= in_item.data_byte;
				end else if (pos < POS_W'(6)) begin
					layout_q[pos[0]*8 +: 8] <= in_item.data_byte;
				end else if (pos < POS_W'(8)) begin
					version_q[pos[0]*8 +: 8] <= in_item.data_byte;
				end else if (pos < POS_W'(12)) begin
					sequence_q[pos[1:0]*8 +: 8] <= in_item.data_byte;
				end else if (pos < POS_W'(14)) begin
					length_q[pos[0]*8 +: 8] <= in_item.data_byte;
				end else if (pos >= POS_W'(16) && pos < POS_W'(20)) begin
					stored_q <= stored_nx;
				end
			end
		end
	end

endmodule

// File: rtl/fsiv_queue.sv
// ----------------------------------------------------------------------------
// Verdict queue
// Short first-in first-out buffer between the parser and the slot table.
// ----------------------------------------------------------------------------
module fsiv_queue import fsiv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  verdict_t push_data,
	output logic     full,
	output logic     pop_valid,
	output verdict_t pop_data,
	input  logic     pop
);

	verdict_t              entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_pop;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

// File: rtl/fsiv_back.sv
// ----------------------------------------------------------------------------
// Slot table
// Applies verdicts to the kept slot marks and registers the result transaction.
// ----------------------------------------------------------------------------
module fsiv_back import fsiv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  verdict_t  q_data,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic        valid_q [SLOT_COUNT];
	logic [31:0] seq_q   [SLOT_COUNT];
	logic        valid_nx [SLOT_COUNT];
	logic [31:0] seq_nx   [SLOT_COUNT];

	logic              out_valid_q;
	out_item_t         out_item_q;
	logic              found;
	logic [SLOT_W-1:0] best;

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			valid_nx[i] = valid_q[i];
			seq_nx[i]   = seq_q[i];
			if (SLOT_W'(q_data.slot) == SLOT_W'(i)) begin
				valid_nx[i] = q_data.ok;
				seq_nx[i]   = q_data.ok ? q_data.sequence_num : 32'd0;
			end
		end
	end

	always_comb begin
		found = 1'b0;
		best  = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (valid_nx[i] && (!found || seq_nx[i] > seq_nx[best])) begin
				best  = SLOT_W'(i);
				found = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				valid_q[i] <= 1'b0;
				seq_q[i]   <= '0;
			end
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					valid_q[i] <= valid_nx[i];
					seq_q[i]   <= seq_nx[i];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_item_q.scanned_slot   <= q_data.slot;
			out_item_q.image_valid    <= q_data.ok;
			out_item_q.sequence_res   <= q_data.ok ? q_data.sequence_num : 32'd0;
			out_item_q.image_version  <= q_data.ok ? q_data.version : 16'd0;
			out_item_q.payload_length <= q_data.ok ? q_data.length : 16'd0;
			out_item_q.newest_present <= found;
			out_item_q.newest_slot    <= found ? best[0] : 1'b0;
		end
	end

endmodule

// File: rtl/flash_slot_image_validator.sv
// A verdict goes through the verdict queue, then the output register of the slot table.
// Throughput: one byte per cycle (bytewise CRC step) while the verdict queue is not full.
// The four-entry verdict queue lets the parser run on while the result side is stalled.
// Reset clears the scan, the slot marks and the queue, and loads the register defaults.
// ----------------------------------------------------------------------------
// Flash slot image validator
// Parses slot image headers, checks the CRC and tracks the newest valid slot.
// ----------------------------------------------------------------------------
module flash_slot_image_validator import fsiv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fsiv_in_if.sink               in_ch,
	fsiv_out_if.source            out_ch
);

	logic     push;
	verdict_t push_data;
	logic     queue_full;
	logic     q_valid;
	verdict_t q_data;
	logic     q_pop;

	fsiv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_item    (in_ch.item),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	fsiv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop_valid (q_valid),
		.pop_data  (q_data),
		.pop       (q_pop)
	);

	fsiv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_item  (out_ch.item)
	);

endmodule

// File: tb/sv/fsiv_verdict_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot verdict checker
// Watches the configuration port and both channels of the slot image
// validator. Every accepted image byte goes through a local model of the
// header parser, the CRC and the kept slot marks. Every accepted verdict is
// compared field by field with the oldest verdict that the model has produced.
// ----------------------------------------------------------------------------
module fsiv_verdict_check import fsiv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_item,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_item,
	output int                    failures,
	output int                    pending
);

	logic [31:0]      want_magic;
	logic [15:0]      want_layout;
	logic [15:0]      len_limit;

	bit               scanning;
	bit               open_slot;
	logic [POS_W-1:0] pos;
	logic [31:0]      hdr_magic;
	logic [15:0]      hdr_layout;
	logic [15:0]      hdr_version;
	logic [31:0]      hdr_seq;
	logic [15:0]      hdr_len;
	logic [31:0]      hdr_crc;
	logic [31:0]      crc_acc;

	bit               kept_valid [SLOT_COUNT];
	logic [31:0]      kept_seq [SLOT_COUNT];

	out_item_t        verdicts_due[$];
	out_item_t        oldest;

	function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	task automatic clear_model();
		want_magic  = '0;
		want_layout = 16'd1;
		len_limit   = 16'hFFFF;
		scanning    = 1'b0;
		open_slot   = 1'b0;
		pos         = '0;
		hdr_magic   = '0;
		hdr_layout  = '0;
		hdr_version = '0;
		hdr_seq     = '0;
		hdr_len     = '0;
		hdr_crc     = '0;
		crc_acc     = CRC_INIT;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			kept_valid[i] = 1'b0;
			kept_seq[i]   = '0;
		end
		verdicts_due.delete();
		failures = 0;
	endtask

	task automatic close_scan(input bit ok);
		out_item_t v;
		int        best;
		bit        found;
		kept_valid[open_slot] = ok;
		kept_seq[open_slot]   = ok ? hdr_seq : 32'd0;
		best  = 0;
		found = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (kept_valid[i] && (!found || kept_seq[i] > kept_seq[best])) begin
				best  = i;
				found = 1'b1;
			end
		end
		v.scanned_slot   = open_slot;
		v.image_valid    = ok;
		v.sequence_res   = ok ? hdr_seq : 32'd0;
		v.image_version  = ok ? hdr_version : 16'd0;
		v.payload_length = ok ? hdr_len : 16'd0;
		v.newest_present = found;
		v.newest_slot    = found ? 1'(best) : 1'b0;
		verdicts_due.push_back(v);
		scanning = 1'b0;
	endtask

	task automatic absorb_byte(input in_item_t it);
		int p;
		if (it.first_byte) begin
			scanning    = 1'b1;
			open_slot   = it.slot;
			pos         = '0;
			hdr_magic   = '0;
			hdr_layout  = '0;
			hdr_version = '0;
			hdr_seq     = '0;
			hdr_len     = '0;
			hdr_crc     = '0;
			crc_acc     = CRC_INIT;
		end
		if (!scanning)
			return;
		if (it.read_failed) begin
			close_scan(1'b0);
			return;
		end
		p = int'(pos);
		if (p < int'(CRC_COVERED))
			crc_acc = crc_next(crc_acc, it.data_byte);
		if (p < 4)
			hdr_magic[8*p +: 8] = it.data_byte;
		else if (p < 6)
			hdr_layout[8*(p-4) +: 8] = it.data_byte;
		else if (p < 8)
			hdr_version[8*(p-6) +: 8] = it.data_byte;
		else if (p < 12)
			hdr_seq[8*(p-8) +: 8] = it.data_byte;
		else if (p < 14)
			hdr_len[8*(p-12) +: 8] = it.data_byte;
		else if (p >= 16 && p < 20)
			hdr_crc[8*(p-16) +: 8] = it.data_byte;
		if (p == HEADER_BYTES - 1) begin
			if (hdr_magic != want_magic || hdr_layout != want_layout || hdr_len > len_limit) begin
				close_scan(1'b0);
				return;
			end
			if (hdr_len == 16'd0) begin
				close_scan(~crc_acc == hdr_crc);
				return;
			end
		end else if (p >= HEADER_BYTES) begin
			crc_acc = crc_next(crc_acc, it.data_byte);
			if (p == HEADER_BYTES + int'(hdr_len) - 1) begin
				close_scan(~crc_acc == hdr_crc);
				return;
			end
		end
		pos = pos + POS_W'(1);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
		end else begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: verdict expected none, got %h", $time, out_item);
					failures++;
				end else begin
					oldest = verdicts_due.pop_front();
					check_field("scanned_slot", 32'(oldest.scanned_slot), 32'(out_item.scanned_slot));
					check_field("image_valid", 32'(oldest.image_valid), 32'(out_item.image_valid));
					check_field("sequence_res", oldest.sequence_res, out_item.sequence_res);
					check_field("image_version", 32'(oldest.image_version),
						32'(out_item.image_version));
					check_field("payload_length", 32'(oldest.payload_length),
						32'(out_item.payload_length));
					check_field("newest_present", 32'(oldest.newest_present),
						32'(out_item.newest_present));
					check_field("newest_slot", 32'(oldest.newest_slot), 32'(out_item.newest_slot));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_EXPECTED_MAGIC: want_magic = cfg_data;
					REG_EXPECTED_LAYOUT: want_layout = cfg_data[15:0];
					REG_MAX_PAYLOAD: len_limit = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				absorb_byte(in_item);
		end
		pending = verdicts_due.size();
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash slot image validator testbench
// Streams directed and random slot images, good and damaged, through the
// validator under several register settings, with random idling on both
// channels, a long result stall and a steady stretch. The verdict checker
// beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module testbench;
	import fsiv_pkg::*;

	typedef enum int {
		FLAW_NONE,
		FLAW_MAGIC,
		FLAW_LAYOUT,
		FLAW_LENGTH,
		FLAW_CRC,
		FLAW_READ_FAIL,
		FLAW_CUT
	} flaw_t;

	localparam int CYCLE_LIMIT   = 50000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fsiv_in_if  in_ch();
	fsiv_out_if out_ch();

	int          failures;
	int          pending;
	int          bytes_sent;
	bit          send_steady;
	bit          recv_steady;
	bit          pressure_on;
	logic [31:0] cur_magic;
	logic [15:0] cur_layout;
	logic [15:0] cur_max;
	in_item_t    byte_plan[$];

	flash_slot_image_validator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	fsiv_verdict_check verdict_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_item   (in_ch.item),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_item  (out_ch.item),
		.failures  (failures),
		.pending   (pending)
	);

	function automatic logic [31:0] image_crc(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic in_item_t make_item(bit slot_id, logic [7:0] b, bit first, bit fail);
		in_item_t it;
		it.slot        = slot_id;
		it.data_byte   = b;
		it.first_byte  = first;
		it.read_failed = fail;
		return it;
	endfunction

	function automatic logic [31:0] pick_sequence();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 2));
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic plan_image(input bit slot_id, input int plen, input flaw_t flaw);
		logic [7:0]  img[$];
		logic [7:0]  body_bytes[$];
		logic [7:0]  b;
		logic [31:0] magic;
		logic [31:0] seq;
		logic [31:0] crc;
		logic [31:0] stored;
		logic [15:0] layout;
		logic [15:0] version;
		logic [15:0] len;
		logic [15:0] spare;
		int          body;
		int          stop_at;
		bit          bad_crc;
		magic   = cur_magic;
		layout  = cur_layout;
		version = 16'($urandom);
		seq     = pick_sequence();
		spare   = 16'($urandom);
		body    = (plen > int'(cur_max)) ? int'(cur_max) : plen;
		len     = 16'(body);
		bad_crc = (flaw == FLAW_CRC) || (flaw == FLAW_LENGTH && cur_max == 16'hFFFF);
		case (flaw)
			FLAW_MAGIC: magic ^= 32'd1 << $urandom_range(0, 31);
			FLAW_LAYOUT: layout ^= 16'd1 << $urandom_range(0, 15);
			FLAW_LENGTH: begin
				if (cur_max != 16'hFFFF)
					len = 16'($urandom_range(int'(cur_max) + 1, 65535));
			end
			default: ;
		endcase
		if (flaw == FLAW_MAGIC || flaw == FLAW_LAYOUT || len > cur_max)
			body = 0;
		for (int i = 0; i < 4; i++) img.push_back(magic[8*i +: 8]);
		for (int i = 0; i < 2; i++) img.push_back(layout[8*i +: 8]);
		for (int i = 0; i < 2; i++) img.push_back(version[8*i +: 8]);
		for (int i = 0; i < 4; i++) img.push_back(seq[8*i +: 8]);
		for (int i = 0; i < 2; i++) img.push_back(len[8*i +: 8]);
		for (int i = 0; i < 2; i++) img.push_back(spare[8*i +: 8]);
		crc = CRC_INIT;
		foreach (img[i]) crc = image_crc(crc, img[i]);
		for (int i = 0; i < body; i++) begin
			b = 8'($urandom);
			body_bytes.push_back(b);
			crc = image_crc(crc, b);
		end
		stored = ~crc;
		if (bad_crc)
			stored ^= 32'd1 << $urandom_range(0, 31);
		for (int i = 0; i < 4; i++) img.push_back(stored[8*i +: 8]);
		foreach (body_bytes[i]) img.push_back(body_bytes[i]);
		stop_at = img.size() - 1;
		if (flaw == FLAW_READ_FAIL)
			stop_at = $urandom_range(0, img.size() - 1);
		else if (flaw == FLAW_CUT)
			stop_at = $urandom_range(1, img.size() - 1);
		for (int i = 0; i <= stop_at; i++)
			byte_plan.push_back(make_item((i == 0) ? slot_id : 1'($urandom), img[i], i == 0,
				flaw == FLAW_READ_FAIL && i == stop_at));
	endtask

	task automatic plan_random_sequence();
		int pick;
		int plen;
		bit slot_id;
		pick    = $urandom_range(0, 99);
		slot_id = 1'($urandom);
		if ($urandom_range(0, 99) < 80)
			plen = $urandom_range(0, 8);
		else if ($urandom_range(0, 3) != 0)
			plen = $urandom_range(9, 40);
		else
			plen = $urandom_range(41, 200);
		if (pick < 60)
			plan_image(slot_id, plen, FLAW_NONE);
		else if (pick < 76)
			plan_image(slot_id, plen, flaw_t'($urandom_range(int'(FLAW_MAGIC), int'(FLAW_CRC))));
		else if (pick < 86)
			plan_image(slot_id, plen, ($urandom_range(0, 1) != 0) ? FLAW_READ_FAIL : FLAW_CUT);
		else if (pick < 93)
			byte_plan.push_back(make_item(slot_id, 8'($urandom), 1'b1, 1'b1));
		else
			repeat ($urandom_range(1, 3))
				byte_plan.push_back(make_item(1'($urandom), 8'($urandom), 1'b0,
					$urandom_range(0, 3) == 0));
	endtask

	task automatic send_byte(input in_item_t it);
		while (!send_steady && $urandom_range(0, 99) < 27) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.item  <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_plan();
		while (byte_plan.size() > 0)
			send_byte(byte_plan.pop_front());
	endtask

	task automatic run_random(input int budget);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			plan_random_sequence();
			send_plan();
		end
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_registers(input logic [31:0] magic, input logic [15:0] layout,
		input logic [15:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_EXPECTED_MAGIC;
		cfg_data  <= magic;
		@(negedge clk);
		cfg_index <= REG_EXPECTED_LAYOUT;
		cfg_data  <= {16'd0, layout};
		@(negedge clk);
		cfg_index <= REG_MAX_PAYLOAD;
		cfg_data  <= {16'd0, limit};
		@(negedge clk);
		cfg_we     <= 1'b0;
		cur_magic  = magic;
		cur_layout = layout;
		cur_max    = limit;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int hold_left;
		bit hold_taken;
		hold_left    = 0;
		hold_taken   = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (pressure_on && !hold_taken) begin
				hold_taken   = 1'b1;
				hold_left    = HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else if (recv_steady) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= 27);
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_EXPECTED_MAGIC;
		cfg_data    = '0;
		in_ch.valid = 1'b0;
		in_ch.item  = '0;
		bytes_sent  = 0;
		send_steady = 1'b0;
		recv_steady = 1'b0;
		pressure_on = 1'b0;
		cur_magic   = 32'd0;
		cur_layout  = 16'd1;
		cur_max     = 16'hFFFF;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		byte_plan.push_back(make_item(1'b1, 8'hFF, 1'b0, 1'b1));
		byte_plan.push_back(make_item(1'b1, 8'h00, 1'b1, 1'b1));
		plan_image(1'b0, 0, FLAW_NONE);
		byte_plan.push_back(make_item(1'b1, 8'h5A, 1'b1, 1'b0));
		byte_plan.push_back(make_item(1'b0, 8'hA5, 1'b0, 1'b1));
		send_plan();
		settle();

		set_registers($urandom, 16'($urandom), 16'd16);
		run_random(170);
		settle();

		pressure_on = 1'b1;
		send_steady = 1'b1;
		repeat (24) byte_plan.push_back(make_item(1'($urandom), 8'($urandom), 1'b1, 1'b1));
		repeat (4) plan_image(1'($urandom), $urandom_range(0, 16), FLAW_NONE);
		send_plan();
		send_steady = 1'b0;
		settle();

		set_registers(32'hFFFF_FFFF, 16'hFFFF, 16'd0);
		run_random(170);
		settle();

		set_registers(32'd0, 16'd0, 16'hFFFF);
		plan_image(1'($urandom), 256, FLAW_NONE);
		send_plan();
		run_random(50);
		settle();

		set_registers($urandom, 16'($urandom), 16'($urandom_range(0, 40)));
		send_steady = 1'b1;
		recv_steady = 1'b1;
		run_random(200);
		send_steady = 1'b0;
		recv_steady = 1'b0;
		run_random(140);
		settle();

		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
